// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define BNRQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bnrq assertion failed");
`else
`define BNRQ_ASSERT(lbl, clk, rst_n, prop)
`endif

`ifndef SYNTH
`define BNRQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bnrq implication failed");
`else
`define BNRQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/bnrq_pkg.sv =====
// ----------------------------------------------------------------------------
// bnrq_pkg
// Types and constants of the int8 batchnorm requantizer.
// ----------------------------------------------------------------------------
package bnrq_pkg;

    localparam int CHANNELS  = 256;
    localparam int CH_W      = 8;
    // entries beyond the channel field range can never be addressed
    localparam int TBL_DEPTH = (CHANNELS < (1 << CH_W)) ? CHANNELS : (1 << CH_W);
    localparam int TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

    localparam logic       MODE_LOAD   = 1'b0;
    localparam logic       MODE_SAMPLE = 1'b1;

    localparam logic       REG_CLAMP_LOW  = 1'b0;
    localparam logic       REG_CLAMP_HIGH = 1'b1;

    localparam logic [7:0] EXP_INF       = 8'hFF;
    localparam int         SCALE_EXP_LIM = 148;
    localparam int         BIAS_EXP_LIM  = 156;
    localparam int         SHIFT_MAX     = 24;
    localparam int         MANT_BIAS     = 150;

    localparam logic signed [7:0] CLAMP_LOW_RST  = -8'sd128;
    localparam logic signed [7:0] CLAMP_HIGH_RST = 8'sd127;

    typedef struct packed {
        logic               mode;
        logic [CH_W-1:0]    channel;
        logic [31:0]        scale_bits;
        logic [31:0]        bias_bits;
        logic signed [7:0]  sample;
        logic               last_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [7:0]  result;
        logic               bad_channel;
        logic               last_out;
    } t_out_item;

    // one channel table entry: |mc| <= 2^22, |bc| < 2^30, shift 1..24
    typedef struct packed {
        logic signed [23:0] mc;
        logic signed [30:0] bc;
        logic [4:0]         shift;
        logic               bad;
    } t_entry;

endpackage

// ===== rtl/int8_batchnorm_requantizer_top.sv =====
// ----------------------------------------------------------------------------
// int8_batchnorm_requantizer_top
// Per-channel int8 requantizer with float32 scale and bias loading.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle while the output does not stall, loads and
// samples in any mix. A load turns the float32 scale and bias bits into
// fixed-point constants in two stages and writes them from stage 2 into a
// single-port-write, single-port-read channel table (256 entries); a sample
// that follows at once picks the fresh entry up by forwarding. A sample reads
// the table in the cycle of its transfer, multiplies and adds in stage 2,
// rounds and clamps in stage 3, and its result is offered from the output
// register. The table read port and the 8x24 multiply-add each run once per
// cycle, which sets the one-item-per-cycle rate. The table needs no clearing
// after reset; samples must only name channels that have been loaded.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module int8_batchnorm_requantizer_top
    import bnrq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // half-even rounding of m / 2^sh, sh in 1..25
    function automatic logic [23:0] rne_shift(input logic [23:0] m, input logic [4:0] sh);
        logic [48:0] t;
        logic [23:0] q;
        t = {m, 25'b0} >> sh;
        q = t[48:25];
        if (t[24] && ((|t[23:0]) || q[0])) begin
            q = q + 24'd1;
        end
        return q;
    endfunction

    // exponent of the lsb of the mantissa after scaling by 2^s
    function automatic logic signed [9:0] lsb_exp(input logic [7:0] ex, input logic [4:0] s);
        logic [7:0] e;
        e = (ex == 8'd0) ? 8'd1 : ex;
        return $signed({2'b00, e}) + $signed({5'b00000, s}) - 10'(MANT_BIAS);
    endfunction

    // configuration
    logic signed [7:0] r_clamp_low;
    logic signed [7:0] r_clamp_high;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clamp_low  <= CLAMP_LOW_RST;
            r_clamp_high <= CLAMP_HIGH_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_CLAMP_LOW:  r_clamp_low  <= pwdata[7:0];
                REG_CLAMP_HIGH: r_clamp_high <= pwdata[7:0];
                default:        r_clamp_low  <= r_clamp_low;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_CLAMP_LOW:  prdata = {{24{r_clamp_low[7]}}, r_clamp_low};
            REG_CLAMP_HIGH: prdata = {{24{r_clamp_high[7]}}, r_clamp_high};
            default:        prdata = 32'd0;
        endcase
    end

    // pipeline control
    logic              r_s1_valid;
    t_in_item          r_s1_data;
    logic              r_s2_valid;
    logic              r_s2_load;
    logic              r_s2_inrange;
    logic [TBL_AW-1:0] r_s2_addr;
    logic [4:0]        r_s2_shift;
    logic [31:0]       r_s2_sb;
    logic [31:0]       r_s2_bb;
    t_entry            r_s2_ent;
    logic signed [7:0] r_s2_sample;
    logic              r_s2_last;
    logic              r_s3_valid;
    logic signed [31:0] r_s3_acc;
    logic [4:0]        r_s3_shift;
    logic              r_s3_bad;
    logic              r_s3_last;
    logic              r_out_valid;
    t_out_item         r_out_data;

    logic can_out, s3_free, s2_free, s1_free, in_xfer;

    assign can_out  = !r_out_valid || i_out_ready;
    assign s3_free  = !r_s3_valid || can_out;
    assign s2_free  = !r_s2_valid || r_s2_load || s3_free;
    assign s1_free  = !r_s1_valid || s2_free;
    assign in_xfer  = i_in_valid && s1_free;

    assign o_in_ready  = s1_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // channel table
    t_entry            mem [TBL_DEPTH];
    t_entry            r_rdata;
    logic              wr_en;
    t_entry            wr_data;
    logic [TBL_AW-1:0] in_addr;
    logic [TBL_AW-1:0] s1_addr;
    logic              s1_inrange;

    assign in_addr    = i_in_data.channel[TBL_AW-1:0];
    assign s1_addr    = r_s1_data.channel[TBL_AW-1:0];
    assign s1_inrange = {1'b0, r_s1_data.channel} < (CH_W + 1)'(TBL_DEPTH);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_s2_addr] <= wr_data;
        end
    end

    // write-first read: a load written at the same edge is seen at once
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            if (wr_en && (r_s2_addr == in_addr)) begin
                r_rdata <= wr_data;
            end else begin
                r_rdata <= mem[in_addr];
            end
        end
    end

    // stage 1: shift choice for loads, entry forwarding for samples
    logic [7:0]        s1_ea, s1_eb;
    logic signed [9:0] lim_a, lim_b, s_pick;
    t_entry            s1_ent;

    always_comb begin
        s1_ea  = r_s1_data.scale_bits[30:23];
        s1_eb  = r_s1_data.bias_bits[30:23];
        lim_a  = 10'(SCALE_EXP_LIM) - $signed({2'b00, s1_ea});
        lim_b  = 10'(BIAS_EXP_LIM) - $signed({2'b00, s1_eb});
        s_pick = 10'(SHIFT_MAX);
        if (s1_ea != 8'd0 && lim_a < s_pick) begin
            s_pick = lim_a;
        end
        if (s1_eb != 8'd0 && lim_b < s_pick) begin
            s_pick = lim_b;
        end
        if (s_pick < 10'sd1) begin
            s_pick = 10'sd1;
        end
        // the load just ahead writes this cycle, after our table read
        if (wr_en && (r_s2_addr == s1_addr)) begin
            s1_ent = wr_data;
        end else begin
            s1_ent = r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_data <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_free) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free && r_s1_valid) begin
            r_s2_load    <= (r_s1_data.mode == MODE_LOAD);
            r_s2_inrange <= s1_inrange;
            r_s2_addr    <= s1_addr;
            r_s2_shift   <= s_pick[4:0];
            r_s2_sb      <= r_s1_data.scale_bits;
            r_s2_bb      <= r_s1_data.bias_bits;
            r_s2_ent     <= s1_ent;
            r_s2_sample  <= r_s1_data.sample;
            r_s2_last    <= r_s1_data.last_sample;
        end
    end

    // stage 2: constant conversion and table write for loads
    logic [7:0]        s2_ea, s2_eb;
    logic [23:0]       s2_ma, s2_mb;
    logic signed [9:0] ka, kb, sha, shb;
    logic [23:0]       qa;
    logic [29:0]       qb;
    logic              bad_a, bad_b, bad_all;
    logic [23:0]       mc_mag;
    logic [30:0]       bc_mag;

    always_comb begin
        s2_ea = r_s2_sb[30:23];
        s2_eb = r_s2_bb[30:23];
        s2_ma = {s2_ea != 8'd0, r_s2_sb[22:0]};
        s2_mb = {s2_eb != 8'd0, r_s2_bb[22:0]};
        ka    = lsb_exp(s2_ea, r_s2_shift);
        kb    = lsb_exp(s2_eb, r_s2_shift);
        sha   = -ka;
        shb   = -kb;
        bad_a = 1'b0;
        bad_b = 1'b0;
        qa    = 24'd0;
        qb    = 30'd0;
        // scale with a non-negative lsb exponent is always at least 2^23
        if (ka >= 10'sd0) begin
            bad_a = 1'b1;
        end else if (sha < 10'sd26) begin
            qa = rne_shift(s2_ma, sha[4:0]);
        end
        priority if (kb >= 10'sd7) begin
            bad_b = 1'b1;
        end else if (kb >= 10'sd0) begin
            qb = {6'd0, s2_mb} << kb[2:0];
        end else if (shb < 10'sd26) begin
            qb = {6'd0, rne_shift(s2_mb, shb[4:0])};
        end else begin
            qb = 30'd0;
        end
        bad_all = (s2_ea == EXP_INF) || (s2_eb == EXP_INF) || bad_a || bad_b ||
                  (qa > 24'h40_0000);
        mc_mag  = bad_all ? 24'd0 : qa;
        bc_mag  = bad_all ? 31'd0 : {1'b0, qb};
        wr_data.mc    = r_s2_sb[31] ? -$signed(mc_mag) : $signed(mc_mag);
        wr_data.bc    = r_s2_bb[31] ? -$signed(bc_mag) : $signed(bc_mag);
        wr_data.shift = r_s2_shift;
        wr_data.bad   = bad_all;
        wr_en = r_s2_valid && r_s2_load && r_s2_inrange;
    end

    // stage 2: multiply-add for samples
    logic signed [31:0] prod, acc;

    always_comb begin
        prod = $signed({{24{r_s2_sample[7]}}, r_s2_sample}) *
               $signed({{8{r_s2_ent.mc[23]}}, r_s2_ent.mc});
        acc  = prod + $signed({r_s2_ent.bc[30], r_s2_ent.bc});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (s3_free) begin
            r_s3_valid <= r_s2_valid && !r_s2_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_free) begin
            r_s3_acc   <= acc;
            r_s3_shift <= r_s2_ent.shift;
            r_s3_bad   <= r_s2_ent.bad || !r_s2_inrange;
            r_s3_last  <= r_s2_last;
        end
    end

    // stage 3: half-away rounding, saturation, activation bounds
    logic              neg;
    logic [32:0]       mag, rnd, shd;
    logic [7:0]        cap;
    logic signed [8:0] v0, v1, v2, lo9, hi9;

    always_comb begin
        neg = r_s3_acc[31];
        mag = neg ? 33'(-$signed({r_s3_acc[31], r_s3_acc})) : {1'b0, r_s3_acc};
        rnd = mag;
        if (r_s3_shift != 5'd0) begin
            rnd = mag + (33'd1 << (r_s3_shift - 5'd1));
        end
        shd = rnd >> r_s3_shift;
        // anything past the int8 range clamps the same way
        cap = (shd > 33'd200) ? 8'd200 : shd[7:0];
        v0  = neg ? -$signed({1'b0, cap}) : $signed({1'b0, cap});
        lo9 = {r_clamp_low[7], r_clamp_low};
        hi9 = {r_clamp_high[7], r_clamp_high};
        v1  = (v0 < lo9) ? lo9 : v0;
        v2  = (v1 > hi9) ? hi9 : v1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (can_out) begin
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (can_out) begin
            r_out_data.result      <= r_s3_bad ? 8'sd0 : v2[7:0];
            r_out_data.bad_channel <= r_s3_bad;
            r_out_data.last_out    <= r_s3_last;
        end
    end

    // a transfer always lands in the first stage
    `BNRQ_ASSERT(a_xfer_lands, i_clk, i_rst_n, in_xfer |=> r_s1_valid)
    // only in-range loads write the table
    `BNRQ_ASSERT_IMPL(a_wr_load, i_clk, i_rst_n, wr_en, r_s2_load && r_s2_inrange)
    // stored shift stays within its legal span
    `BNRQ_ASSERT_IMPL(a_wr_shift, i_clk, i_rst_n, wr_en,
                      wr_data.shift >= 5'd1 && wr_data.shift <= 5'(SHIFT_MAX))
    // a bad channel keeps zero constants
    `BNRQ_ASSERT_IMPL(a_wr_bad_zero, i_clk, i_rst_n, wr_en && wr_data.bad,
                      wr_data.mc == 24'sd0 && wr_data.bc == 31'sd0)
    // a held result is never overwritten by the stage behind it
    `BNRQ_ASSERT(a_hold_s3, i_clk, i_rst_n,
                 (r_out_valid && !i_out_ready && r_s3_valid) |=> r_s3_valid)

endmodule

// ===== tb/tb_int8_batchnorm_requantizer_top.sv =====
// ----------------------------------------------------------------------------
// tb_int8_batchnorm_requantizer_top
// Self-checking bench for the int8 per-channel batchnorm requantizer.
// ----------------------------------------------------------------------------
// Loads float32 scale and bias pairs into the channel table and streams int8
// samples through, with random gaps on the input side and random stalls on
// the output side. A small scoreboard keeps its own copy of the channel
// table and the activation bounds, turns every accepted load into fixed-point
// constants, predicts each sample's result and compares it field by field
// with what the block returns. The bounds are rewritten over the APB port
// between phases while the block is idle, extremes and inverted bounds among
// them.
// ----------------------------------------------------------------------------
module tb_int8_batchnorm_requantizer_top;
    import bnrq_pkg::*;

    localparam int RUN_LIMIT    = 400000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 244;
    localparam int SETTLE_LAT   = 8;

    class requant_scoreboard;
        t_out_item  pending_outputs[$];
        int         chan_mc[CHANNELS];
        int         chan_bc[CHANNELS];
        int         chan_shift[CHANNELS];
        bit         chan_bad[CHANNELS];
        int         bound_lo;
        int         bound_hi;
        int         errors;

        function new();
            bound_lo = CLAMP_LOW_RST;
            bound_hi = CLAMP_HIGH_RST;
            errors   = 0;
        endfunction

        function void set_bound(logic reg_sel, logic signed [7:0] value);
            if (reg_sel == REG_CLAMP_LOW) begin
                bound_lo = value;
            end else begin
                bound_hi = value;
            end
        endfunction

        // |float| * 2^shift, rounded half to even; too_big when a nonzero lsb weighs >= 2^32
        function longint unsigned fixed_magnitude(logic [31:0] bits, int shift,
                                                  output bit too_big);
            int              expo;
            int              k;
            int              drop;
            longint unsigned mant;
            longint unsigned quo;
            longint unsigned rem;
            longint unsigned half;
            too_big = 1'b0;
            mant    = bits[22:0];
            expo    = 1;
            if (bits[30:23] != 8'd0) begin
                mant = mant | 64'h80_0000;
                expo = bits[30:23];
            end
            k = expo - MANT_BIAS + shift;
            if (k >= 0) begin
                if (k >= 32) begin
                    too_big = (mant != 0);
                    return 0;
                end
                return mant << k;
            end
            drop = -k;
            if (drop >= 26) return 0;
            quo  = mant >> drop;
            rem  = mant & ((64'd1 << drop) - 1);
            half = 64'd1 << (drop - 1);
            if (rem > half || (rem == half && quo[0])) quo = quo + 1;
            return quo;
        endfunction

        function void load_channel(int ch, logic [31:0] scale, logic [31:0] bias);
            int              ea;
            int              eb;
            int              shift;
            bit              big_m;
            bit              big_b;
            bit              bad;
            longint unsigned mag_m;
            longint unsigned mag_b;
            ea    = scale[30:23];
            eb    = bias[30:23];
            shift = SHIFT_MAX;
            // a zero exponent places no limit on the shift
            if (ea != 0 && SCALE_EXP_LIM - ea < shift) shift = SCALE_EXP_LIM - ea;
            if (eb != 0 && BIAS_EXP_LIM - eb < shift) shift = BIAS_EXP_LIM - eb;
            if (shift < 1) shift = 1;
            mag_m = fixed_magnitude(scale, shift, big_m);
            mag_b = fixed_magnitude(bias, shift, big_b);
            bad = (ea == EXP_INF) || (eb == EXP_INF) || big_m || big_b ||
                  (mag_m > (64'd1 << 22)) || (mag_b >= (64'd1 << 30));
            chan_shift[ch] = shift;
            chan_bad[ch]   = bad;
            chan_mc[ch]    = 0;
            chan_bc[ch]    = 0;
            if (!bad) begin
                chan_mc[ch] = scale[31] ? -int'(mag_m) : int'(mag_m);
                chan_bc[ch] = bias[31] ? -int'(mag_b) : int'(mag_b);
            end
        endfunction

        function t_out_item requantize(int ch, logic signed [7:0] x, logic last);
            t_out_item res;
            longint    acc;
            longint    mag;
            int        v;
            res.last_out    = last;
            res.result      = '0;
            res.bad_channel = 1'b1;
            if (ch >= CHANNELS || chan_bad[ch]) return res;
            acc = longint'(x) * chan_mc[ch] + chan_bc[ch];
            mag = (acc < 0) ? -acc : acc;
            // round half away from zero on the magnitude
            if (chan_shift[ch] > 0) begin
                mag = (mag + (64'sd1 << (chan_shift[ch] - 1))) >> chan_shift[ch];
            end
            if (mag > 1000) mag = 1000;
            v = (acc < 0) ? -int'(mag) : int'(mag);
            // low bound first, so the high bound wins when they cross
            if (v < bound_lo) v = bound_lo;
            if (v > bound_hi) v = bound_hi;
            res.result      = v[7:0];
            res.bad_channel = 1'b0;
            return res;
        endfunction

        function void note_input(t_in_item it);
            if (it.mode == MODE_LOAD) begin
                if (int'(it.channel) < CHANNELS) begin
                    load_channel(it.channel, it.scale_bits, it.bias_bits);
                end
            end else begin
                pending_outputs.push_back(requantize(it.channel, it.sample,
                                                     it.last_sample));
            end
        endfunction

        function void check_output(t_out_item got);
            t_out_item want;
            if (pending_outputs.size() == 0) begin
                $error("unexpected result transfer: result=%0d bad_channel=%0b last_out=%0b",
                       got.result, got.bad_channel, got.last_out);
                errors++;
                return;
            end
            want = pending_outputs.pop_front();
            if (got.result !== want.result) begin
                $error("result: expected %0d, got %0d", want.result, got.result);
                errors++;
            end
            if (got.bad_channel !== want.bad_channel) begin
                $error("bad_channel: expected %0b, got %0b", want.bad_channel,
                       got.bad_channel);
                errors++;
            end
            if (got.last_out !== want.last_out) begin
                $error("last_out: expected %0b, got %0b", want.last_out, got.last_out);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_data;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    requant_scoreboard sb;
    int  cycle_count = 0;
    bit  send_pace   = 1'b1;
    bit  recv_pace   = 1'b1;
    bit  is_loaded[CHANNELS];
    int  loaded_list[$];
    int  last_load_ch = 0;

    int8_batchnorm_requantizer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_output(o_out_data);
        end
    end

    // output side back-pressure, one stall draw per result transfer
    initial begin : out_pacing
        int stall;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = recv_pace ? $urandom_range(0, 8) : 0;
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
        end
    end

    task automatic send_item(t_in_item it);
        int gap;
        gap = send_pace ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(it);
        if (it.mode == MODE_LOAD) begin
            last_load_ch = it.channel;
            if (!is_loaded[it.channel]) begin
                is_loaded[it.channel] = 1'b1;
                loaded_list.push_back(it.channel);
            end
        end
    endtask

    // stop sending and let every pending result and table write finish
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending_outputs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_LAT) @(posedge i_clk);
    endtask

    task automatic write_bound(logic reg_sel, int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_bound(reg_sel, 8'(value));
        // the bus idles before the next access
        @(posedge i_clk);
    endtask

    function automatic t_in_item load_item(int ch, logic [31:0] scale,
                                           logic [31:0] bias);
        t_in_item it;
        it.mode        = MODE_LOAD;
        it.channel     = 8'(ch);
        it.scale_bits  = scale;
        it.bias_bits   = bias;
        it.sample      = 8'($urandom);
        it.last_sample = 1'($urandom);
        return it;
    endfunction

    function automatic t_in_item sample_item(int ch, int x, logic last);
        t_in_item it;
        it.mode        = MODE_SAMPLE;
        it.channel     = 8'(ch);
        it.scale_bits  = $urandom;
        it.bias_bits   = $urandom;
        it.sample      = 8'(x);
        it.last_sample = last;
        return it;
    endfunction

    function automatic logic [31:0] rand_float(int elo, int ehi);
        return {1'($urandom), 8'($urandom_range(ehi, elo)), 23'($urandom)};
    endfunction

    // zeros, infinities, nans, denormals and exponents around the shift limits
    function automatic logic [31:0] odd_float();
        case ($urandom_range(0, 6))
            0:       return 32'h0000_0000;
            1:       return 32'h8000_0000;
            2:       return {1'($urandom), EXP_INF, 23'd0};
            3:       return {1'($urandom), EXP_INF, 23'($urandom) | 23'd1};
            4:       return {1'($urandom), 8'd0, 23'($urandom)};
            5:       return rand_float(145, 157);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_item make_item();
        t_in_item it;
        int       pick;
        int       ch;
        if (loaded_list.size() == 0 || $urandom_range(0, 99) < 25) begin
            it   = load_item($urandom_range(0, 255), $urandom, $urandom);
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                it.scale_bits = rand_float(112, 128);
                it.bias_bits  = ($urandom_range(0, 9) == 0) ? 32'h0 : rand_float(115, 134);
            end else if (pick < 85) begin
                it.scale_bits = odd_float();
                it.bias_bits  = rand_float(115, 134);
            end else if (pick < 90) begin
                it.scale_bits = rand_float(112, 128);
                it.bias_bits  = odd_float();
            end
        end else begin
            if (is_loaded[last_load_ch] && $urandom_range(0, 2) == 0) begin
                ch = last_load_ch;
            end else begin
                ch = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
            end
            it = sample_item(ch, $urandom_range(0, 255), $urandom_range(0, 7) == 0);
        end
        return it;
    endfunction

    initial begin : stimulus
        int lo;
        int hi;
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // unit gain, full-range samples
        send_item(load_item(0, 32'h3F80_0000, 32'h0000_0000));
        send_item(sample_item(0, 127, 1'b0));
        send_item(sample_item(0, -128, 1'b0));
        send_item(sample_item(0, 0, 1'b1));
        // negative scale with negative zero bias, -63.5 rounds away from zero
        send_item(load_item(255, 32'hBF00_0000, 32'h8000_0000));
        send_item(sample_item(255, -128, 1'b0));
        send_item(sample_item(255, 127, 1'b1));
        // infinite scale and nan bias both mark the channel bad
        send_item(load_item(1, 32'h7F80_0000, 32'h3F00_0000));
        send_item(sample_item(1, 5, 1'b0));
        send_item(load_item(2, 32'h3F80_0000, 32'hFFC0_0000));
        send_item(sample_item(2, -7, 1'b1));
        // shift pinned at one, mc exactly at the limit, then just over it
        send_item(load_item(3, 32'h4A00_0000, 32'h0000_0000));
        send_item(sample_item(3, 1, 1'b0));
        send_item(sample_item(3, -1, 1'b0));
        send_item(load_item(4, 32'h4A00_0003, 32'h0000_0000));
        send_item(sample_item(4, 1, 1'b0));
        // bias too large, and a large bias that still fits
        send_item(load_item(5, 32'h3C00_0000, 32'h4E00_0000));
        send_item(sample_item(5, 3, 1'b0));
        send_item(load_item(6, 32'h3C00_0000, 32'hCD80_0000));
        send_item(sample_item(6, 127, 1'b1));
        // denormal scale and bias
        send_item(load_item(7, 32'h0000_0001, 32'h8040_0000));
        send_item(sample_item(7, -128, 1'b0));
        // exact halves round away from zero
        send_item(load_item(8, 32'h3F00_0000, 32'h3F00_0000));
        send_item(sample_item(8, 0, 1'b0));
        send_item(sample_item(8, -2, 1'b1));

        for (int p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0:       begin lo = -128; hi = 127;  end
                1:       begin lo = -128; hi = -128; end
                2:       begin lo = 127;  hi = 127;  end
                3:       begin lo = 10;   hi = -10;  end
                4:       begin lo = -5;   hi = 5;    end
                5:       begin lo = 0;    hi = 127;  end
                default: begin
                    lo = $urandom_range(0, 255) - 128;
                    hi = $urandom_range(0, 255) - 128;
                end
            endcase
            write_bound(REG_CLAMP_LOW, lo);
            write_bound(REG_CLAMP_HIGH, hi);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // stretches of back-to-back transfers between paced ones
                if (n % 40 == 0) begin
                    send_pace = ($urandom_range(0, 3) != 0);
                    recv_pace = ($urandom_range(0, 3) != 0);
                end
                send_item(make_item());
            end
        end

        drain();
        if (sb.errors == 0 && sb.pending_outputs.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
